>>> rtl/i2p_pkg.sv
package i2p_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int VALUE_WIDTH = 16;
    localparam int PTR_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);

    typedef enum logic [2:0] {
        MODE_OPERAND  = 3'd0,
        MODE_OPERATOR = 3'd1,
        MODE_OPEN     = 3'd2,
        MODE_CLOSE    = 3'd3,
        MODE_END      = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        KIND_OPERAND  = 2'd0,
        KIND_OPERATOR = 2'd1,
        KIND_STATUS   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_OVERFLOW  = 2'd1,
        ERR_UNM_CLOSE = 2'd2,
        ERR_UNM_OPEN  = 2'd3
    } err_t;

    // stack entry: operator code 0..3, open paren mark
    localparam logic [2:0] OPEN_MARK = 3'd4;

    typedef struct packed {
        kind_t                   kind;
        logic [1:0]              op;
        logic [VALUE_WIDTH-1:0]  value;
        err_t                    error;
        logic                    last;
    } result_t;

    // add/sub rank 1, mul/div rank 2, open paren rank 0
    function automatic logic [1:0] rank(input logic [2:0] entry);
        logic [1:0] r;
        if (entry == 3'd0 || entry == 3'd1)
        begin
            r = 2'd1;
        end
        else if (entry == 3'd2 || entry == 3'd3)
        begin
            r = 2'd2;
        end
        else
        begin
            r = 2'd0;
        end
        return r;
    endfunction

endpackage

>>> rtl/infix_to_postfix_converter_unit.sv
// Shunting-yard infix to postfix converter. One classified token enters per item on the
// slave stream and the postfix tokens it releases leave on the master stream; tlast marks
// the last result item of each input item, and an input item that releases nothing gives no
// result item at all. Operators and open parens live in a 16-entry synchronous stack
// memory whose top entry is read back in the cycle after every push or pop, with the
// written data forwarded into the top register when a push lands on the address being
// read. Steps: an item is taken, then the sequencer pops the stack one entry per step and
// ends with a closing step; an operand, a plain push or an empty end has only the closing
// step, and a close paren that meets its open paren closes in the step that pops it.
// The sequencer stalls while the output register is full and not taken. Results pass
// through a one-deep pending register so that tlast and the error code can be placed on
// the final item; a new input item is taken as soon as the sequencer is idle, even while
// the last result still waits in the output register. Stack overflow drops the token and
// reports error 1, a close paren that finds no open paren reports error 2, and open parens
// left at end report 3; with nothing else to carry the code, a status-only item (tuser
// kind 2) is sent.
module infix_to_postfix_converter_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // op_code[1:0], operand_value[17:2], zero pad
    input  logic [2:0]  s_axis_tuser,   // mode[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // out_op[1:0], out_value[17:2], error[19:18], pad
    output logic [1:0]  m_axis_tuser,   // tok_kind[1:0]
    output logic        m_axis_tlast    // last
);

    typedef enum logic {
        ST_IDLE,
        ST_BUSY
    } state_t;

    localparam int VW = i2p_pkg::VALUE_WIDTH;

    state_t                         state_reg, state_next;
    logic [i2p_pkg::PTR_W-1:0]      sp_reg, sp_next;
    i2p_pkg::mode_t                 mode_reg, mode_next;
    logic [1:0]                     op_reg, op_next;
    logic [VW-1:0]                  value_reg, value_next;
    logic                           found_reg, found_next;   // open paren seen during end
    logic                           pend_valid_reg, pend_valid_next;
    i2p_pkg::result_t               pend_reg, pend_next;
    logic                           out_valid_reg, out_valid_next;
    i2p_pkg::result_t               out_reg, out_next;

    // stack memory and its registered top-of-stack read
    logic [2:0]                     stack_mem [i2p_pkg::STACK_DEPTH];
    logic [2:0]                     top_reg;
    logic                           mem_we;
    logic [i2p_pkg::ADDR_W-1:0]     wr_addr;
    logic [2:0]                     wr_data;
    logic [i2p_pkg::ADDR_W-1:0]     rd_addr;
    logic [i2p_pkg::PTR_W-1:0]      sp_dec;

    logic                           slot_free;
    logic                           have_top;
    logic                           stack_full;
    logic                           do_emit;
    logic                           do_finish;
    logic                           do_pop;
    logic                           do_push;
    logic [2:0]                     push_entry;
    i2p_pkg::err_t                  fin_err;
    i2p_pkg::result_t               cand;

    assign slot_free  = !out_valid_reg || m_axis_tready;
    assign have_top   = (sp_reg != '0);
    assign stack_full = (sp_reg == i2p_pkg::PTR_W'(i2p_pkg::STACK_DEPTH));

    // read address follows the next stack pointer so top_reg is the live top
    assign sp_dec  = sp_next - 1'b1;
    assign rd_addr = sp_dec[i2p_pkg::ADDR_W-1:0];
    assign wr_addr = sp_reg[i2p_pkg::ADDR_W-1:0];
    assign wr_data = push_entry;

    always_comb
    begin
        state_next      = state_reg;
        sp_next         = sp_reg;
        mode_next       = mode_reg;
        op_next         = op_reg;
        value_next      = value_reg;
        found_next      = found_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_next        = out_reg;

        do_emit    = 1'b0;
        do_finish  = 1'b0;
        do_pop     = 1'b0;
        do_push    = 1'b0;
        push_entry = {1'b0, op_reg};
        fin_err    = i2p_pkg::ERR_NONE;
        mem_we     = 1'b0;

        // operator popped from the top, the usual candidate result
        cand       = '0;
        cand.kind  = i2p_pkg::KIND_OPERATOR;
        cand.op    = top_reg[1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    mode_next  = i2p_pkg::mode_t'(s_axis_tuser);
                    op_next    = s_axis_tdata[1:0];
                    value_next = s_axis_tdata[VW+1:2];
                    found_next = 1'b0;
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY:
            begin
                if (slot_free)
                begin
                    unique case (mode_reg)
                        i2p_pkg::MODE_OPERAND:
                        begin
                            // goes straight to the output as a single last item
                            out_valid_next  = 1'b1;
                            out_next        = '0;
                            out_next.kind   = i2p_pkg::KIND_OPERAND;
                            out_next.value  = value_reg;
                            out_next.last   = 1'b1;
                            state_next      = ST_IDLE;
                        end
                        i2p_pkg::MODE_OPERATOR:
                        begin
                            if (have_top && (i2p_pkg::rank(top_reg) >=
                                             i2p_pkg::rank({1'b0, op_reg})))
                            begin
                                do_pop  = 1'b1;
                                do_emit = 1'b1;
                            end
                            else if (!stack_full)
                            begin
                                do_push   = 1'b1;
                                do_finish = 1'b1;
                            end
                            else
                            begin
                                do_finish = 1'b1;
                                fin_err   = i2p_pkg::ERR_OVERFLOW;
                            end
                        end
                        i2p_pkg::MODE_OPEN:
                        begin
                            push_entry = i2p_pkg::OPEN_MARK;
                            do_finish  = 1'b1;
                            if (!stack_full)
                            begin
                                do_push = 1'b1;
                            end
                            else
                            begin
                                fin_err = i2p_pkg::ERR_OVERFLOW;
                            end
                        end
                        i2p_pkg::MODE_CLOSE:
                        begin
                            if (have_top)
                            begin
                                do_pop = 1'b1;
                                if (top_reg == i2p_pkg::OPEN_MARK)
                                begin
                                    do_finish = 1'b1;
                                end
                                else
                                begin
                                    do_emit = 1'b1;
                                end
                            end
                            else
                            begin
                                do_finish = 1'b1;
                                fin_err   = i2p_pkg::ERR_UNM_CLOSE;
                            end
                        end
                        i2p_pkg::MODE_END:
                        begin
                            if (have_top)
                            begin
                                do_pop = 1'b1;
                                if (top_reg == i2p_pkg::OPEN_MARK)
                                begin
                                    found_next = 1'b1;
                                end
                                else
                                begin
                                    do_emit = 1'b1;
                                end
                            end
                            else
                            begin
                                do_finish = 1'b1;
                                fin_err   = found_reg ? i2p_pkg::ERR_UNM_OPEN
                                                      : i2p_pkg::ERR_NONE;
                            end
                        end
                        default:
                        begin
                            // unused token kinds are dropped silently
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (do_pop)
        begin
            sp_next = sp_reg - 1'b1;
        end
        if (do_push)
        begin
            mem_we  = 1'b1;
            sp_next = sp_reg + 1'b1;
        end

        // a new candidate pushes the previous pending item out as a non-last item
        if (do_emit)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = pend_reg;
                out_next.last  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_next       = cand;
        end

        // closing step: pending item becomes last and carries the error code
        if (do_finish)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = pend_reg;
                out_next.error = fin_err;
                out_next.last  = 1'b1;
            end
            else if (fin_err != i2p_pkg::ERR_NONE)
            begin
                out_valid_next = 1'b1;
                out_next       = '0;
                out_next.kind  = i2p_pkg::KIND_STATUS;
                out_next.error = fin_err;
                out_next.last  = 1'b1;
            end
            pend_valid_next = 1'b0;
            state_next      = ST_IDLE;
        end
    end

    // control state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            sp_reg         <= '0;
            found_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sp_reg         <= sp_next;
            found_reg      <= found_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        op_reg    <= op_next;
        value_reg <= value_next;
        pend_reg  <= pend_next;
        out_reg   <= out_next;
    end

    // stack memory, write first forwarding into the top register
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[wr_addr] <= wr_data;
        end
        if (mem_we && (wr_addr == rd_addr))
        begin
            top_reg <= wr_data;
        end
        else
        begin
            top_reg <= stack_mem[rd_addr];
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_reg.error, out_reg.value, out_reg.op};
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tlast  = out_reg.last;

    // stack pointer never goes past the stack depth
    a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= i2p_pkg::PTR_W'(i2p_pkg::STACK_DEPTH))
        else $error("stack pointer beyond depth");

    // no result may be left pending once the sequencer goes idle
    a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("pending result left while idle");

    // a status-only item always closes its input item and carries an error
    a_status_item: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == i2p_pkg::KIND_STATUS))
            |-> (m_axis_tlast && (m_axis_tdata[19:18] != i2p_pkg::ERR_NONE)))
        else $error("status item without error or last");

    // the stack moves by at most one entry per cycle
    a_sp_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ((sp_reg == $past(sp_reg)) || (sp_reg == $past(sp_reg) + 1'b1)
                  || (sp_reg + 1'b1 == $past(sp_reg))))
        else $error("stack pointer jumped");

endmodule

>>> tb/sv/tb_infix_to_postfix_converter_unit.sv
`timescale 1ns / 100ps

import i2p_pkg::*;

// postfix token queue with its own shunting-yard stack
class postfix_scoreboard;
    logic [2:0] op_stack_mirror [STACK_DEPTH];
    int         stack_fill;
    result_t    postfix_q [$];
    int         failures;

    function new();
        stack_fill = 0;
        failures   = 0;
    endfunction

    task report(input string what);
        if (failures < 40)
        begin
            $display("[%0t] mismatch: %s", $time, what);
        end
        failures++;
    endtask

    function int priority_of(input logic [2:0] entry);
        int p;
        if (entry == 3'd0 || entry == 3'd1)
        begin
            p = 1;
        end
        else if (entry == 3'd2 || entry == 3'd3)
        begin
            p = 2;
        end
        else
        begin
            p = 0;
        end
        return p;
    endfunction

    function result_t make_tok(input kind_t kind, input logic [1:0] op,
                               input logic [VALUE_WIDTH-1:0] value);
        result_t t;
        t.kind  = kind;
        t.op    = op;
        t.value = value;
        t.error = ERR_NONE;
        t.last  = 1'b0;
        return t;
    endfunction

    function err_t push_entry(input logic [2:0] entry);
        err_t status;
        if (stack_fill >= STACK_DEPTH)
        begin
            status = ERR_OVERFLOW;
        end
        else
        begin
            op_stack_mirror[stack_fill] = entry;
            stack_fill++;
            status = ERR_NONE;
        end
        return status;
    endfunction

    // work out the postfix tokens released by one accepted infix token
    function void note_token(input logic [2:0] mode, input logic [1:0] op,
                             input logic [VALUE_WIDTH-1:0] value);
        result_t    released [$];
        result_t    tok;
        err_t       status;
        logic [2:0] top;
        bit         open_seen;
        status    = ERR_NONE;
        open_seen = 1'b0;
        case (mode)
            MODE_OPERAND:
            begin
                released.push_back(make_tok(KIND_OPERAND, 2'd0, value));
            end
            MODE_OPERATOR:
            begin
                while (stack_fill > 0 &&
                       priority_of(op_stack_mirror[stack_fill-1]) >= priority_of({1'b0, op}))
                begin
                    stack_fill--;
                    released.push_back(make_tok(KIND_OPERATOR,
                                                op_stack_mirror[stack_fill][1:0], '0));
                end
                status = push_entry({1'b0, op});
            end
            MODE_OPEN:
            begin
                status = push_entry(OPEN_MARK);
            end
            MODE_CLOSE:
            begin
                while (stack_fill > 0 && !open_seen)
                begin
                    stack_fill--;
                    top = op_stack_mirror[stack_fill];
                    if (top == OPEN_MARK)
                    begin
                        open_seen = 1'b1;
                    end
                    else
                    begin
                        released.push_back(make_tok(KIND_OPERATOR, top[1:0], '0));
                    end
                end
                if (!open_seen)
                begin
                    status = ERR_UNM_CLOSE;
                end
            end
            MODE_END:
            begin
                while (stack_fill > 0)
                begin
                    stack_fill--;
                    top = op_stack_mirror[stack_fill];
                    if (top == OPEN_MARK)
                    begin
                        open_seen = 1'b1;
                    end
                    else
                    begin
                        released.push_back(make_tok(KIND_OPERATOR, top[1:0], '0));
                    end
                end
                if (open_seen)
                begin
                    status = ERR_UNM_OPEN;
                end
            end
            default:
            begin
            end
        endcase
        if (status != ERR_NONE)
        begin
            if (released.size() == 0)
            begin
                tok = make_tok(KIND_STATUS, 2'd0, '0);
            end
            else
            begin
                tok = released.pop_back();
            end
            tok.error = status;
            released.push_back(tok);
        end
        if (released.size() > 0)
        begin
            tok      = released.pop_back();
            tok.last = 1'b1;
            released.push_back(tok);
        end
        foreach (released[i])
        begin
            postfix_q.push_back(released[i]);
        end
    endfunction

    task check_result(input result_t got);
        result_t want;
        if (postfix_q.size() == 0)
        begin
            report($sformatf("unexpected result kind %0d op %0d value %h error %0d last %0d",
                             got.kind, got.op, got.value, got.error, got.last));
            return;
        end
        want = postfix_q.pop_front();
        if (got.kind !== want.kind)
        begin
            report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
        end
        if (got.op !== want.op)
        begin
            report($sformatf("operator %0d, expected %0d", got.op, want.op));
        end
        if (got.value !== want.value)
        begin
            report($sformatf("value %h, expected %h", got.value, want.value));
        end
        if (got.error !== want.error)
        begin
            report($sformatf("error %0d, expected %0d", got.error, want.error));
        end
        if (got.last !== want.last)
        begin
            report($sformatf("last %0d, expected %0d", got.last, want.last));
        end
    endtask

    task flush_leftovers();
        if (postfix_q.size() > 0)
        begin
            report($sformatf("%0d results never arrived", postfix_q.size()));
            postfix_q.delete();
        end
    endtask
endclass

module tb_infix_to_postfix_converter_unit;

    localparam int CLK_PERIOD      = 20;
    localparam int RESET_CYCLES    = 10;
    localparam int RANDOM_ITEMS    = 450;
    localparam int PHASE_ITEMS     = 90;
    localparam int MAX_GAP         = 16;
    localparam int MAX_NEST        = 6;
    // nothing accepted for this long means the block is hung
    localparam int IDLE_LIMIT      = 2000;
    // one long receiver hold-off, after this many results
    localparam int HOLD_OFF_AT     = 60;
    localparam int HOLD_OFF_CYCLES = 400;
    // room for an item that pops a full stack, with margin
    localparam int DRAIN_CYCLES    = 40;

    // operator codes carried in op_code
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;
    // a mode the block must ignore
    localparam logic [2:0] MODE_UNUSED = 3'd7;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;    // op_code[1:0], operand_value[17:2], zero pad
    logic [2:0]  s_axis_tuser  = '0;    // mode[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;          // out_op[1:0], out_value[17:2], error[19:18], pad
    logic [1:0]  m_axis_tuser;          // tok_kind[1:0]
    logic        m_axis_tlast;          // last

    // idling bounds for the current phase, 0 means back-to-back
    int tx_max_gap   = MAX_GAP;
    int rx_max_stall = MAX_GAP;
    // items of modes 0..4 sent, ignored modes excluded
    int token_count  = 0;
    int idle_cycles  = 0;

    postfix_scoreboard sb;
    result_t           seen_tok;

    infix_to_postfix_converter_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // offer one token, holding tvalid across back-to-back items
    task automatic send_token(input logic [2:0] mode, input logic [1:0] op,
                              input logic [VALUE_WIDTH-1:0] value);
        int gap;
        gap = (tx_max_gap > 0) ? $urandom_range(0, tx_max_gap) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {6'b0, value, op};
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        if (mode <= MODE_END)
        begin
            token_count++;
        end
    endtask

    // well-formed infix expression with random nesting, then end
    task automatic send_expression(input int terms);
        int nest;
        int i;
        nest = 0;
        for (i = 0; i < terms; i++)
        begin
            while (nest < MAX_NEST && $urandom_range(0, 3) == 0)
            begin
                send_token(MODE_OPEN, 2'($urandom), 16'($urandom));
                nest++;
            end
            send_token(MODE_OPERAND, 2'($urandom), 16'($urandom));
            while (nest > 0 && $urandom_range(0, 2) == 0)
            begin
                send_token(MODE_CLOSE, 2'($urandom), 16'($urandom));
                nest--;
            end
            if (i < terms - 1)
            begin
                send_token(MODE_OPERATOR, 2'($urandom), 16'($urandom));
            end
        end
        while (nest > 0)
        begin
            send_token(MODE_CLOSE, 2'($urandom), 16'($urandom));
            nest--;
        end
        send_token(MODE_END, 2'($urandom), 16'($urandom));
    endtask

    // arbitrary tokens, ignored modes included, usually leaving the stack unbalanced
    task automatic send_noise(input int count);
        int i;
        for (i = 0; i < count; i++)
        begin
            send_token(3'($urandom_range(0, 7)), 2'($urandom), 16'($urandom));
        end
    endtask

    // open paren plus operator per level; the deeper runs fill the stack and run into overflow
    task automatic send_deep_nest(input int levels);
        int i;
        for (i = 0; i < levels; i++)
        begin
            send_token(MODE_OPEN, 2'($urandom), 16'($urandom));
            send_token(MODE_OPERAND, 2'($urandom), 16'($urandom));
            send_token(MODE_OPERATOR, 2'($urandom), 16'($urandom));
        end
        send_token(MODE_OPERAND, 2'($urandom), 16'($urandom));
        if ($urandom_range(0, 1) == 0)
        begin
            send_token(MODE_CLOSE, 2'($urandom), 16'($urandom));
        end
        send_token(MODE_END, 2'($urandom), 16'($urandom));
    endtask

    // compare accepted results and note accepted tokens, both sampled at the edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen_tok.kind  = kind_t'(m_axis_tuser);
                seen_tok.op    = m_axis_tdata[1:0];
                seen_tok.value = m_axis_tdata[17:2];
                seen_tok.error = err_t'(m_axis_tdata[19:18]);
                seen_tok.last  = m_axis_tlast;
                sb.check_result(seen_tok);
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                sb.note_token(s_axis_tuser, s_axis_tdata[1:0], s_axis_tdata[17:2]);
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off so the block backs up
    initial
    begin
        int  stall;
        int  taken;
        bit  held;
        taken = 0;
        held  = 1'b0;
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            stall = (rx_max_stall > 0) ? $urandom_range(0, rx_max_stall) : 0;
            if (!held && taken == HOLD_OFF_AT)
            begin
                stall = HOLD_OFF_CYCLES;
                held  = 1'b1;
            end
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!m_axis_tvalid);
            taken++;
        end
    end

    initial
    begin
        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // close paren on an empty stack gives a lone unmatched-close status
        send_token(MODE_CLOSE, OP_ADD, 16'h0000);
        // extreme operands; add pops divide; close then finds no open paren
        send_token(MODE_OPERAND, OP_ADD, 16'hFFFF);
        send_token(MODE_OPERATOR, OP_DIV, 16'h0000);
        send_token(MODE_OPERAND, OP_ADD, 16'h0000);
        send_token(MODE_OPERATOR, OP_ADD, 16'h0000);
        send_token(MODE_CLOSE, OP_ADD, 16'h0000);
        // end with an empty stack and an empty paren pair give nothing
        send_token(MODE_END, OP_ADD, 16'h0000);
        send_token(MODE_OPEN, OP_ADD, 16'h0000);
        send_token(MODE_CLOSE, OP_ADD, 16'h0000);
        // ignored mode
        send_token(MODE_UNUSED, OP_DIV, 16'hFFFF);
        // fill the stack: 15 open parens plus multiply
        repeat (15) send_token(MODE_OPEN, OP_ADD, 16'h0000);
        send_token(MODE_OPERAND, OP_ADD, 16'h5A5A);
        send_token(MODE_OPERATOR, OP_MUL, 16'h0000);
        // full stack drops the open paren with an overflow status
        send_token(MODE_OPEN, OP_ADD, 16'h0000);
        // subtract pops multiply, so it finds room
        send_token(MODE_OPERATOR, OP_SUB, 16'h0000);
        send_token(MODE_OPERAND, OP_ADD, 16'hA5A5);
        // end discards the open parens, unmatched-open lands on subtract
        send_token(MODE_END, OP_ADD, 16'h0000);

        // random part, idling pattern changes every phase
        token_count = 0;
        while (token_count < RANDOM_ITEMS)
        begin
            case ((token_count / PHASE_ITEMS) % 4)
                0:
                begin
                    tx_max_gap   = MAX_GAP;
                    rx_max_stall = MAX_GAP;
                end
                1:
                begin
                    tx_max_gap   = 0;
                    rx_max_stall = 0;
                end
                2:
                begin
                    tx_max_gap   = MAX_GAP;
                    rx_max_stall = 0;
                end
                default:
                begin
                    tx_max_gap   = 0;
                    rx_max_stall = MAX_GAP;
                end
            endcase
            case ($urandom_range(0, 19))
                0, 1, 2:
                begin
                    send_noise($urandom_range(1, 10));
                end
                3:
                begin
                    send_deep_nest($urandom_range(6, 10));
                end
                default:
                begin
                    send_expression($urandom_range(1, 8));
                end
            endcase
        end
        s_axis_tvalid <= 1'b0;

        // drain, then give late or extra results time to show up
        while (sb.postfix_q.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.flush_leftovers();
        if (sb.failures == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/i2p_pkg.sv
rtl/infix_to_postfix_converter_unit.sv
tb/sv/tb_infix_to_postfix_converter_unit.sv
